// ===== sv/p2v_pkg.sv =====
// Shared types and constants for the phoneme to viseme mapper.
// No dependencies; imported by the front end, the result queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package p2v_pkg;

    localparam logic [7:0] CHAR_LO = 8'd97;   // 'a'
    localparam logic [7:0] CHAR_HI = 8'd122;  // 'z'

    localparam logic [4:0] CLOSE_LIMIT = 5'd12;
    localparam logic [4:0] MAX_VISEME  = 5'd25;

    // letter indexes, a = 0
    localparam logic [4:0] L_A = 5'd0;
    localparam logic [4:0] L_B = 5'd1;
    localparam logic [4:0] L_C = 5'd2;
    localparam logic [4:0] L_D = 5'd3;
    localparam logic [4:0] L_E = 5'd4;
    localparam logic [4:0] L_F = 5'd5;
    localparam logic [4:0] L_G = 5'd6;
    localparam logic [4:0] L_H = 5'd7;
    localparam logic [4:0] L_I = 5'd8;
    localparam logic [4:0] L_J = 5'd9;
    localparam logic [4:0] L_K = 5'd10;
    localparam logic [4:0] L_L = 5'd11;
    localparam logic [4:0] L_M = 5'd12;
    localparam logic [4:0] L_N = 5'd13;
    localparam logic [4:0] L_O = 5'd14;
    localparam logic [4:0] L_P = 5'd15;
    localparam logic [4:0] L_R = 5'd17;
    localparam logic [4:0] L_S = 5'd18;
    localparam logic [4:0] L_T = 5'd19;
    localparam logic [4:0] L_U = 5'd20;
    localparam logic [4:0] L_V = 5'd21;
    localparam logic [4:0] L_W = 5'd22;
    localparam logic [4:0] L_X = 5'd23;
    localparam logic [4:0] L_Y = 5'd24;
    localparam logic [4:0] L_Z = 5'd25;

    typedef struct packed {
        logic [4:0] viseme;
        logic       last;
    } p2v_result_t;

    // up to two results produced by one accepted item, in order
    typedef struct packed {
        logic [1:0]        cnt;
        p2v_result_t [1:0] res;
    } p2v_push_t;

endpackage

`default_nettype wire

// ===== sv/p2v_front.sv =====
// Front end: accepts characters, tracks the waiting letter and held viseme,
// and resolves phoneme codes into up to two result items. Uses p2v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p2v_front
    import p2v_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] character,
    input  wire logic       space_ok,
    output p2v_push_t       push
);

    typedef struct packed {
        logic       used;
        logic       close;
        logic [1:0] n;
        logic [4:0] e0;
        logic [4:0] e1;
    } resolve_t;

    // first letter f against next letter s (s_ok low for a terminator)
    function automatic resolve_t resolve(input logic [4:0] f, input logic s_ok,
                                         input logic [4:0] s);
        resolve_t r;
        r = '0;
        case (f)
            L_A: begin
                if (s_ok && s == L_X) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd22;
                end else if (s_ok && (s == L_A || s == L_H)) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd15;
                end else if (s_ok && (s == L_E || s == L_Y)) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd16;
                end else if (s_ok && (s == L_O || s == L_W)) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd17;
                end
            end
            L_E: begin
                if (s_ok && s == L_R) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd22;
                end else if (s_ok && s == L_H) begin
                    r.used = 1'b1; r.close = 1'b1; r.n = 2'd1; r.e0 = 5'd16;
                end else if (s_ok && s == L_Y) begin
                    r.used = 1'b1; r.close = 1'b1; r.n = 2'd1; r.e0 = 5'd21;
                end
            end
            L_I: begin
                if (s_ok && (s == L_H || s == L_Y)) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd23;
                end
            end
            L_N: begin
                r.n = 2'd1;
                if (s_ok && s == L_G) begin
                    r.used = 1'b1; r.e0 = 5'd21;
                end else begin
                    r.e0 = 5'd1;
                end
            end
            L_L: begin
                r.n = 2'd1; r.e0 = 5'd3;
            end
            L_Z, L_C, L_S: begin
                r.n = 2'd1;
                if (s_ok && s == L_H) begin
                    r.used = 1'b1; r.e0 = 5'd9;
                end else begin
                    r.e0 = 5'd11;
                end
            end
            L_R: begin
                r.n = 2'd1; r.e0 = 5'd25;
            end
            L_G, L_K: begin
                r.n = 2'd1; r.e0 = 5'd5;
            end
            L_H: begin
                if (s_ok && s == L_H) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd5;
                end
            end
            L_B, L_P, L_M: begin
                r.n = 2'd1; r.e0 = 5'd13;
            end
            L_O: begin
                r.close = 1'b1;
                if (s_ok && s == L_W) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd19;
                end else if (s_ok && s == L_Y) begin
                    r.used = 1'b1; r.n = 2'd2; r.e0 = 5'd17; r.e1 = 5'd23;
                end
            end
            L_F: begin
                r.n = 2'd1; r.e0 = 5'd14;
            end
            L_V: begin
                r.n = 2'd1; r.e0 = 5'd24;
            end
            L_D, L_T: begin
                r.n = 2'd1;
                if (s_ok && s == L_H) begin
                    r.used = 1'b1; r.e0 = 5'd7;
                end else begin
                    r.e0 = 5'd1;
                end
            end
            L_W: begin
                r.n = 2'd1; r.e0 = 5'd18;
            end
            L_J: begin
                if (s_ok && s == L_H) begin
                    r.used = 1'b1; r.n = 2'd2; r.e0 = 5'd10; r.e1 = 5'd23;
                end
            end
            L_Y: begin
                r.n = 2'd1; r.e0 = 5'd23;
            end
            L_U: begin
                r.close = 1'b1;
                if (s_ok && s == L_W) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd19;
                end else if (s_ok && s == L_H) begin
                    r.used = 1'b1; r.n = 2'd1; r.e0 = 5'd24;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    logic       pending_valid_reg, pending_valid_next;
    logic [4:0] pending_letter_reg, pending_letter_next;
    logic       held_valid_reg, held_valid_next;
    logic [4:0] held_viseme_reg, held_viseme_next;

    logic       accept;
    logic       is_letter;
    logic [4:0] letter;

    assign in_ready  = space_ok;
    assign accept    = in_valid && space_ok;
    assign is_letter = (character >= CHAR_LO) && (character <= CHAR_HI);
    assign letter    = 5'(character - CHAR_LO);

    always_comb
    begin
        resolve_t   r;
        logic [1:0] n;
        r                   = '0;
        n                   = 2'd0;
        push                = '0;
        pending_valid_next  = pending_valid_reg;
        pending_letter_next = pending_letter_reg;
        held_valid_next     = held_valid_reg;
        held_viseme_next    = held_viseme_reg;
        if (accept)
        begin
            if (pending_valid_reg)
            begin
                r = resolve(pending_letter_reg, is_letter, letter);
            end
            if (r.close && held_valid_next && held_viseme_next < CLOSE_LIMIT)
            begin
                held_viseme_next = 5'(held_viseme_next + 5'd1);
            end
            // each new viseme pushes the held one out
            if (r.n != 2'd0)
            begin
                if (held_valid_next)
                begin
                    push.res[n[0]] = '{viseme: held_viseme_next, last: 1'b0};
                    n = 2'(n + 2'd1);
                end
                held_viseme_next = r.e0;
                held_valid_next  = 1'b1;
            end
            if (r.n == 2'd2)
            begin
                push.res[n[0]] = '{viseme: held_viseme_next, last: 1'b0};
                n = 2'(n + 2'd1);
                held_viseme_next = r.e1;
            end
            if (is_letter)
            begin
                if (!pending_valid_reg || !r.used)
                begin
                    pending_valid_next  = 1'b1;
                    pending_letter_next = letter;
                end
                else
                begin
                    pending_valid_next = 1'b0;
                end
            end
            else
            begin
                // end of string: flush held viseme, or a closed mouth if none
                push.res[n[0]] = '{viseme: (held_valid_next ? held_viseme_next : 5'd0),
                                   last: 1'b1};
                n = 2'(n + 2'd1);
                pending_valid_next  = 1'b0;
                pending_letter_next = 5'd0;
                held_valid_next     = 1'b0;
                held_viseme_next    = 5'd0;
            end
        end
        push.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg  <= 1'b0;
            pending_letter_reg <= 5'd0;
            held_valid_reg     <= 1'b0;
            held_viseme_reg    <= 5'd0;
        end
        else
        begin
            pending_valid_reg  <= pending_valid_next;
            pending_letter_reg <= pending_letter_next;
            held_valid_reg     <= held_valid_next;
            held_viseme_reg    <= held_viseme_next;
        end
    end

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_letter) |=> (!pending_valid_reg && !held_valid_reg))
        else $error("state not cleared after end of string");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (!push.res[0].last))
        else $error("first of two results marked last");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (held_viseme_reg <= MAX_VISEME))
        else $error("held viseme out of range");

endmodule

`default_nettype wire

// ===== sv/p2v_queue.sv =====
// Result queue: takes up to two result items per cycle from the front end
// and hands them out one per cycle while out_ready is high. Uses p2v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p2v_queue
    import p2v_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire p2v_push_t  push,
    output logic            space_ok,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [4:0]      mouth_shape,
    output logic            last
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + PW'(1));
    endfunction

    p2v_result_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_1;
    logic          pop;

    assign wr_ptr_1    = ptr_inc(wr_ptr_reg);
    assign out_valid   = (count_reg != '0);
    assign pop         = out_valid && out_ready;
    assign mouth_shape = mem_reg[rd_ptr_reg].viseme;
    assign last        = mem_reg[rd_ptr_reg].last;
    // room for the worst case of two results from the next item
    assign space_ok    = (count_reg <= CW'(DEPTH - 2));

    always_comb
    begin
        count_next  = CW'(count_reg + CW'(push.cnt) - CW'(pop));
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res[0];
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= push.res[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> ((count_reg + CW'(push.cnt)) <= CW'(DEPTH)))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == CW'($past(count_reg) + CW'($past(push.cnt))
                                   - CW'($past(pop)))))
        else $error("queue count mismatch");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// ===== sv/phoneme_to_viseme_mapper_core.sv =====
// Phoneme to viseme mapper, top level. Takes one character per item and
// returns viseme ids. A character is accepted every cycle while the result
// queue has two free entries; each result item leaves in the cycle after the
// character that produced it at the earliest, one per cycle. A string never
// yields more results than characters, so with the output always ready the
// queue never fills and one character is taken every cycle; only output
// stalls hold off the input. Depends on p2v_pkg, p2v_front and p2v_queue.
`timescale 1ns / 1ps
`default_nettype none

module phoneme_to_viseme_mapper_core
    import p2v_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] character,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [4:0]      mouth_shape,
    output logic            last
);

    p2v_push_t push;
    logic      space_ok;

    p2v_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .character(character),
        .space_ok (space_ok),
        .push     (push)
    );

    p2v_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mouth_shape(mouth_shape),
        .last       (last)
    );

endmodule

`default_nettype wire

// ===== test/tb_phoneme_to_viseme_mapper_core.sv =====
// Self-checking bench for phoneme_to_viseme_mapper_core: phoneme strings in,
// viseme ids out, checked against a built-in viseme table and hold-back logic.
// Depends on p2v_pkg and the RTL of the mapper.
`timescale 1ns / 1ps

module tb_phoneme_to_viseme_mapper_core
    import p2v_pkg::*;
();

    localparam int          NUM_CODES   = 40;
    localparam int          ITEM_TARGET = 2000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          HOLD_AFTER  = 150;
    localparam int          DRAIN_WAIT  = 16;
    localparam logic [4:0]  NO_LETTER   = 5'h1F;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] character = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [4:0] mouth_shape;
    logic       last;

    phoneme_to_viseme_mapper_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .character   (character),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mouth_shape (mouth_shape),
        .last        (last)
    );

    string phoneme_codes [NUM_CODES] = '{
        "aa", "ae", "ah", "ao", "aw", "ax", "ay", "b", "ch", "d",
        "dh", "eh", "er", "ey", "f", "g", "hh", "ih", "iy", "jh",
        "k", "l", "m", "n", "ng", "ow", "oy", "p", "r", "s",
        "sh", "t", "th", "uh", "uw", "v", "w", "y", "z", "zh"
    };

    logic [7:0]  char_queue [$];
    p2v_result_t viseme_expect [$];

    // mirror of the mapper state
    logic       letter_waiting = 1'b0;
    logic [4:0] waiting_letter = 5'd0;
    logic       viseme_held = 1'b0;
    logic [4:0] held_id = 5'd0;

    int unsigned mismatches = 0;
    int unsigned visemes_seen = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------- prediction

    // a new viseme pushes the held one out as a non-final result
    function automatic void push_viseme(input logic [4:0] v);
        p2v_result_t r;
        if (viseme_held) begin
            r.viseme = held_id;
            r.last   = 1'b0;
            viseme_expect.insert(viseme_expect.size(), r);
        end
        held_id     = v;
        viseme_held = 1'b1;
    endfunction

    function automatic void close_mouth();
        if (viseme_held && held_id < CLOSE_LIMIT)
            held_id = held_id + 5'd1;
    endfunction

    // first letter f against next letter s; returns 1 if s is part of the code
    function automatic bit resolve_code(input logic [4:0] f, input logic [4:0] s);
        bit used;
        used = 1'b0;
        case (f)
            L_A: begin
                if (s == L_X) begin push_viseme(5'd22); used = 1'b1; end
                else if (s == L_A || s == L_H) begin push_viseme(5'd15); used = 1'b1; end
                else if (s == L_E || s == L_Y) begin push_viseme(5'd16); used = 1'b1; end
                else if (s == L_O || s == L_W) begin push_viseme(5'd17); used = 1'b1; end
            end
            L_E: begin
                if (s == L_R) begin push_viseme(5'd22); used = 1'b1; end
                else if (s == L_H) begin close_mouth(); push_viseme(5'd16); used = 1'b1; end
                else if (s == L_Y) begin close_mouth(); push_viseme(5'd21); used = 1'b1; end
            end
            L_I: begin
                if (s == L_H || s == L_Y) begin push_viseme(5'd23); used = 1'b1; end
            end
            L_N: begin
                if (s == L_G) begin push_viseme(5'd21); used = 1'b1; end
                else push_viseme(5'd1);
            end
            L_L: push_viseme(5'd3);
            L_Z, L_C, L_S: begin
                if (s == L_H) begin push_viseme(5'd9); used = 1'b1; end
                else push_viseme(5'd11);
            end
            L_R: push_viseme(5'd25);
            L_G, L_K: push_viseme(5'd5);
            L_H: begin
                if (s == L_H) begin push_viseme(5'd5); used = 1'b1; end
            end
            L_B, L_P, L_M: push_viseme(5'd13);
            L_O: begin
                close_mouth();
                if (s == L_W) begin push_viseme(5'd19); used = 1'b1; end
                else if (s == L_Y) begin
                    push_viseme(5'd17);
                    push_viseme(5'd23);
                    used = 1'b1;
                end
            end
            L_F: push_viseme(5'd14);
            L_V: push_viseme(5'd24);
            L_D, L_T: begin
                if (s == L_H) begin push_viseme(5'd7); used = 1'b1; end
                else push_viseme(5'd1);
            end
            L_W: push_viseme(5'd18);
            L_J: begin
                if (s == L_H) begin
                    push_viseme(5'd10);
                    push_viseme(5'd23);
                    used = 1'b1;
                end
            end
            L_Y: push_viseme(5'd23);
            L_U: begin
                close_mouth();
                if (s == L_W) begin push_viseme(5'd19); used = 1'b1; end
                else if (s == L_H) begin push_viseme(5'd24); used = 1'b1; end
            end
            default: used = 1'b0;
        endcase
        return used;
    endfunction

    function automatic void map_char(input logic [7:0] c);
        logic [7:0]  offset;
        logic [4:0]  idx;
        p2v_result_t r;
        if (c >= CHAR_LO && c <= CHAR_HI) begin
            offset = c - CHAR_LO;
            idx    = offset[4:0];
            if (!letter_waiting) begin
                letter_waiting = 1'b1;
                waiting_letter = idx;
            end else if (resolve_code(waiting_letter, idx)) begin
                letter_waiting = 1'b0;
            end else begin
                waiting_letter = idx;
            end
        end else begin
            if (letter_waiting)
                void'(resolve_code(waiting_letter, NO_LETTER));
            letter_waiting = 1'b0;
            waiting_letter = 5'd0;
            // empty string still closes with a single 0
            r.viseme = viseme_held ? held_id : 5'd0;
            r.last   = 1'b1;
            viseme_expect.insert(viseme_expect.size(), r);
            viseme_held = 1'b0;
            held_id     = 5'd0;
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    initial begin
        logic [7:0] opening [24];
        int         kind;
        int         count;
        string      code;
        logic [7:0] term;

        opening = '{
            "t", "e", "h", "j", "h", "o", "y", 8'h00, 8'hFF, 8'h60, 8'h7B,
            "s", "u", "x", "a", "z", 8'h80, "q", 8'h20,
            "n", "g", "d", "h", 8'h7F
        };
        foreach (opening[i])
            char_queue.insert(char_queue.size(), opening[i]);

        while (char_queue.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                count = $urandom_range(1, 8);
                repeat (count) begin
                    code = phoneme_codes[$urandom_range(0, NUM_CODES - 1)];
                    for (int k = 0; k < code.len(); k++)
                        char_queue.insert(char_queue.size(), code[k]);
                end
            end else if (kind < 92) begin
                count = $urandom_range(1, 6);
                repeat (count)
                    char_queue.insert(char_queue.size(),
                                      CHAR_LO + 8'($urandom_range(0, 25)));
            end
            do
                term = 8'($urandom_range(0, 255));
            while (term >= CHAR_LO && term <= CHAR_HI);
            char_queue.insert(char_queue.size(), term);
        end
    end

    // ---------------------------------------------------------------- driver

    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            character <= 8'h00;
        end else begin
            if (in_valid && in_ready)
                map_char(character);
            if (!in_valid || in_ready) begin
                if (gap_left != 0 || char_queue.size() == 0) begin
                    if (gap_left != 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end else begin
                    in_valid  <= 1'b1;
                    character <= char_queue.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic [5:0]  ready_phase = 6'd0;
    logic [1:0]  ready_mode = 2'd0;
    logic [15:0] ready_pat = 16'hA5C3;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && visemes_seen >= HOLD_AFTER) begin
            // long hold-off so the result queue fills and in_ready drops
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            ready_phase <= ready_phase + 6'd1;
            if (ready_phase == 6'd63) begin
                ready_mode <= 2'($urandom_range(0, 3));
                ready_pat  <= 16'($urandom);
            end else if (ready_mode == 2'd2) begin
                ready_pat <= {ready_pat[0], ready_pat[15:1]};
            end
            case (ready_mode)
                2'd0:    out_ready <= 1'b1;
                2'd1:    out_ready <= 1'($urandom_range(0, 1));
                2'd2:    out_ready <= ready_pat[0];
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk) begin : viseme_monitor
        p2v_result_t want;
        if (rst_n && out_valid && out_ready) begin
            visemes_seen <= visemes_seen + 1;
            if (viseme_expect.size() == 0) begin
                $error("unexpected item: mouth_shape %0d last %0b", mouth_shape, last);
                mismatches++;
            end else begin
                want = viseme_expect.pop_front();
                if (mouth_shape !== want.viseme) begin
                    $error("mouth_shape: expected %0d, actual %0d", want.viseme,
                           mouth_shape);
                    mismatches++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- end of run

    initial begin
        @(posedge rst_n);
        @(posedge clk);
        while (char_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (viseme_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("phoneme_to_viseme_mapper_core regression: pass");
        else
            $display("phoneme_to_viseme_mapper_core regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("phoneme_to_viseme_mapper_core regression: fail");
        $finish;
    end

endmodule
